>>> sv/sps_pkg.sv
// shared types and constants for the segmented prime sieve
// no dependencies
`timescale 1ns / 1ps
package sps_pkg;
  localparam int SegSize = 1024;
  localparam int BaseLimit = 1024;
  localparam int ValueBits = 20;
  localparam int SegAw = $clog2(SegSize);
  localparam int BaseAw = $clog2(BaseLimit);
  localparam int WordsMax = SegSize / 64;
  localparam int WordAw = (WordsMax > 1) ? $clog2(WordsMax) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_BINIT, ST_BSCAN, ST_BMARK, ST_SINIT,
    ST_PSCAN, ST_PDIV, ST_PMARK, ST_OUT, ST_ERR
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic binit;
    logic bscan;
    logic bmark;
    logic sinit;
    logic pscan;
    logic pdiv;
    logic pmark;
    logic out_step;
    logic err;
  } cmd_t;

  typedef struct packed {
    logic bad_range;
    logic binit_done;
    logic bscan_hit;
    logic bscan_done;
    logic bmark_done;
    logic sinit_done;
    logic pscan_hit;
    logic pscan_done;
    logic pdiv_done;
    logic pmark_done;
    logic out_done;
    logic out_busy;
  } stat_t;
endpackage

>>> sv/sps_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
module sps_ram #(
  parameter int Width = 1,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sps_ctrl.sv
// sieve sequencer state machine
// depends on sps_pkg
`timescale 1ns / 1ps
module sps_ctrl import sps_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_fire,
  input  stat_t  st,
  output cmd_t   cmd,
  output logic   busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire) state_next = ST_CHECK;
      ST_CHECK: state_next = st.bad_range ? ST_ERR : ST_BINIT;
      ST_ERR:   if (!st.out_busy) state_next = ST_IDLE;
      ST_BINIT: if (st.binit_done) state_next = ST_BSCAN;
      ST_BSCAN: begin
        if (st.bscan_done) state_next = ST_SINIT;
        else if (st.bscan_hit) state_next = ST_BMARK;
      end
      ST_BMARK: if (st.bmark_done) state_next = ST_BSCAN;
      ST_SINIT: if (st.sinit_done) state_next = ST_PSCAN;
      ST_PSCAN: begin
        if (st.pscan_done) state_next = ST_OUT;
        else if (st.pscan_hit) state_next = ST_PDIV;
      end
      ST_PDIV:  if (st.pdiv_done) state_next = ST_PMARK;
      ST_PMARK: if (st.pmark_done) state_next = ST_PSCAN;
      ST_OUT:   if (st.out_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    unique case (state)
      ST_CHECK: cmd.check = 1'b1;
      ST_ERR:   cmd.err = 1'b1;
      ST_BINIT: cmd.binit = 1'b1;
      ST_BSCAN: cmd.bscan = 1'b1;
      ST_BMARK: cmd.bmark = 1'b1;
      ST_SINIT: cmd.sinit = 1'b1;
      ST_PSCAN: cmd.pscan = 1'b1;
      ST_PDIV:  cmd.pdiv = 1'b1;
      ST_PMARK: cmd.pmark = 1'b1;
      ST_OUT:   cmd.out_step = 1'b1;
      default:  ;
    endcase
    busy = (state != ST_IDLE);
  end
endmodule

>>> sv/sps_dp.sv
// sieve datapath: base and segment bitmaps, divider, marker, word packer
// depends on sps_pkg and sps_ram
`timescale 1ns / 1ps
module sps_dp import sps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [ValueBits-1:0] lo_in,
  input  logic [ValueBits-1:0] hi_in,
  output stat_t                st,
  output logic                 o_valid,
  input  logic                 o_ready,
  output logic [63:0]          o_flags,
  output logic [3:0]           o_index,
  output logic                 o_last,
  output logic                 o_err
);
  localparam int CntW = BaseAw + 2;
  localparam int MulW = ValueBits + 2;
  localparam int LenW = SegAw + 1;
  localparam int QW = ValueBits + 1;

  logic [ValueBits-1:0] lo, hi;
  logic [LenW-1:0]      len;
  logic [CntW-1:0]      ptr;
  logic [CntW-1:0]      prime;
  logic [MulW-1:0]      mult;
  logic [2:0]           phase;

  logic                 b_we, b_wd, b_rd;
  logic [BaseAw-1:0]    b_wa, b_ra;
  logic                 s_we, s_wd, s_rd;
  logic [SegAw-1:0]     s_wa, s_ra;

  sps_ram #(.Width(1), .Depth(BaseLimit)) u_base (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  sps_ram #(.Width(1), .Depth(SegSize)) u_seg (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  // restoring divider for ceil(lo/p)
  logic [QW-1:0]  dnum, quo;
  logic [CntW:0]  drem;
  logic [$clog2(QW+1)-1:0] dcnt;
  logic [CntW:0]  trial;
  assign trial = {drem[CntW-1:0], dnum[QW-1]};

  logic [MulW-1:0] psq;
  logic [2*CntW-1:0] psq_full;
  assign psq_full = prime * prime;
  assign psq = MulW'(psq_full);

  logic [MulW-1:0] qmul;
  logic [QW+CntW-1:0] qmul_full;
  assign qmul_full = quo * prime;
  assign qmul = MulW'(qmul_full);

  logic [MulW-1:0] idxw;
  assign idxw = mult - MulW'(lo);

  logic [MulW-1:0] diff;
  assign diff = MulW'(hi) - MulW'(lo);

  logic [WordAw:0] wcnt, nwords;
  logic [6:0]      bitk;
  logic [63:0]     acc;
  logic            rd_pend;
  logic [6:0]      rd_bit;
  logic            pack_done;

  assign nwords = (WordAw+1)'((len + LenW'(63)) >> 6);

  always_comb begin
    b_we = 1'b0; b_wa = ptr[BaseAw-1:0]; b_wd = 1'b0;
    b_ra = ptr[BaseAw-1:0];
    s_we = 1'b0; s_wa = ptr[SegAw-1:0]; s_wd = 1'b0;
    s_ra = ptr[SegAw-1:0];
    st = '0;
    st.bad_range = (hi < lo) || (diff >= MulW'(SegSize));
    st.binit_done = cmd.binit && (ptr == CntW'(BaseLimit - 1));
    if (cmd.binit) begin
      b_we = 1'b1; b_wd = (ptr >= CntW'(2));
    end
    st.bscan_done = cmd.bscan &&
      (CntW'(ptr * ptr) >= CntW'(BaseLimit) || ptr >= CntW'(BaseLimit));
    st.bscan_hit = cmd.bscan && phase == 3'd1 && b_rd;
    st.bmark_done = cmd.bmark && (mult >= MulW'(BaseLimit));
    if (cmd.bmark && !st.bmark_done) begin
      b_we = 1'b1; b_wa = mult[BaseAw-1:0]; b_wd = 1'b0;
    end
    st.sinit_done = cmd.sinit && (ptr == CntW'(len - 1));
    if (cmd.sinit) begin
      s_we = 1'b1; s_wd = (MulW'(lo) + MulW'(ptr)) >= MulW'(2);
    end
    st.pscan_done = cmd.pscan &&
      (ptr >= CntW'(BaseLimit) || MulW'(ptr) * MulW'(ptr) > MulW'(hi));
    st.pscan_hit = cmd.pscan && phase == 3'd1 && b_rd;
    st.pdiv_done = cmd.pdiv && phase == 3'd3;
    st.pmark_done = cmd.pmark && (mult > MulW'(hi));
    if (cmd.pmark && !st.pmark_done) begin
      s_we = 1'b1; s_wa = idxw[SegAw-1:0]; s_wd = 1'b0;
    end
    if (cmd.out_step) s_ra = {wcnt[WordAw-1:0], bitk[5:0]};
    st.out_done = cmd.out_step && pack_done && wcnt == nwords;
    st.out_busy = o_valid;
  end

  // the scan states read the base map at ptr: phase 0 issues, phase 1 sees data
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= lo_in; hi <= hi_in;
    end
    if (cmd.check) begin
      len <= LenW'(diff + 1);
      ptr <= '0;
      phase <= '0;
    end
    if (cmd.binit) begin
      ptr <= st.binit_done ? CntW'(2) : ptr + 1'b1;
      phase <= '0;
    end
    if (cmd.bscan) begin
      if (phase == 3'd0) begin
        phase <= 3'd1;
      end else if (b_rd) begin
        prime <= ptr;
        mult <= MulW'(ptr * ptr);
        phase <= '0;
      end else begin
        ptr <= ptr + 1'b1; phase <= '0;
      end
      if (st.bscan_done) ptr <= '0;
    end
    if (cmd.bmark) begin
      mult <= mult + MulW'(prime);
      if (st.bmark_done) ptr <= ptr + 1'b1;
    end
    if (cmd.sinit) begin
      ptr <= st.sinit_done ? CntW'(2) : ptr + 1'b1;
      phase <= '0;
    end
    if (cmd.pscan) begin
      if (phase == 3'd0) begin
        phase <= 3'd1;
      end else if (b_rd) begin
        prime <= ptr;
        phase <= 3'd2;
        dnum <= QW'(lo) + QW'(ptr) - 1'b1;
        drem <= '0;
        dcnt <= '0;
      end else begin
        ptr <= ptr + 1'b1; phase <= '0;
      end
    end
    if (cmd.pdiv) begin
      if (phase == 3'd2) begin
        if (trial >= (CntW+1)'(prime)) begin
          drem <= trial - (CntW+1)'(prime);
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          drem <= trial;
          quo <= {quo[QW-2:0], 1'b0};
        end
        dnum <= {dnum[QW-2:0], 1'b0};
        dcnt <= dcnt + 1'b1;
        if (dcnt == ($clog2(QW+1))'(QW - 1)) phase <= 3'd3;
      end else begin
        mult <= (qmul < psq) ? psq : qmul;
        phase <= '0;
      end
    end
    if (cmd.pmark && st.pmark_done) ptr <= ptr + 1'b1;
    if (cmd.pmark && !st.pmark_done) mult <= mult + MulW'(prime);
  end

  // word packer: one bit a cycle from the segment map, a word per 64 bits, held while the previous word is unaccepted
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      wcnt <= '0; bitk <= '0; rd_pend <= 1'b0; pack_done <= 1'b0;
    end else begin
      if (o_valid && o_ready) o_valid <= 1'b0;
      if (cmd.err && !o_valid) begin
        o_valid <= 1'b1;
        o_flags <= '0; o_index <= '0; o_last <= 1'b1; o_err <= 1'b1;
      end
      if (cmd.pscan && st.pscan_done) begin
        wcnt <= '0; bitk <= '0; rd_pend <= 1'b0; pack_done <= 1'b0;
        acc <= '0;
      end
      if (cmd.out_step && !pack_done) begin
        if (rd_pend) begin
          if (s_rd && (LenW'({wcnt[WordAw-1:0], rd_bit[5:0]}) < len))
            acc[rd_bit[5:0]] <= 1'b1;
        end
        if (bitk < 7'd64) begin
          rd_pend <= 1'b1; rd_bit <= bitk; bitk <= bitk + 1'b1;
        end else begin
          rd_pend <= 1'b0;
          if (!rd_pend) pack_done <= 1'b1;
        end
      end
      if (cmd.out_step && pack_done && wcnt != nwords && !o_valid) begin
        o_valid <= 1'b1;
        o_flags <= acc;
        o_index <= 4'(wcnt);
        o_last <= (wcnt + 1'b1 == nwords);
        o_err <= 1'b0;
        acc <= '0;
        wcnt <= wcnt + 1'b1;
        bitk <= '0;
        pack_done <= (wcnt + 1'b1 == nwords);
      end
    end
  end
endmodule

>>> sv/segmented_prime_sieve_unit.sv
// segmented prime sieve top level
// depends on sps_pkg, sps_ctrl, sps_dp
//
// channel | dir | tdata                                  | tuser       | tlast
// s_axis  | in  | [19:0] low_bound, [39:20] high_bound   | -           | -
// m_axis  | out | [63:0] prime_flags, [67:64] word_index | range_error | last_word
//
// base sieve first, then segment init over every number of the range, then per base
// prime up to the root of the high bound a scan, a divide and a clear of each multiple,
// then each word is packed from the segment map and sent.
// a rejected range answers with a single error word; a stalled m_axis holds the next word back.
// one request in flight; s_axis_tready low until its last word is presented.
// rst is synchronous, active high.
`timescale 1ns / 1ps
module segmented_prime_sieve_unit import sps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // low_bound, high_bound
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // prime_flags, word_index
  output logic        m_axis_tuser,  // range_error
  output logic        m_axis_tlast   // last_word
);
  cmd_t  cmd;
  stat_t st;
  logic  busy, in_fire;
  logic [63:0] flags;
  logic [3:0]  idx;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  sps_ctrl u_ctrl (.clk, .rst, .in_fire, .st, .cmd, .busy);
  sps_dp u_dp (
    .clk, .rst, .cmd,
    .lo_in(s_axis_tdata[ValueBits-1:0]),
    .hi_in(s_axis_tdata[20 +: ValueBits]),
    .st,
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
    .o_flags(flags), .o_index(idx), .o_last(m_axis_tlast), .o_err(m_axis_tuser));

  assign m_axis_tdata = {4'b0000, idx, flags};
endmodule

>>> test/tb_top.sv
// testbench for segmented_prime_sieve_unit: range requests in, prime flag words out
// checks every output word against a behavioral sieve; depends on sps_pkg and the rtl
`timescale 1ns / 1ps
module tb_top import sps_pkg::*; ();

  typedef struct {
    logic [63:0] flags;
    logic [3:0]  widx;
    logic        last;
    logic        err;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  segmented_prime_sieve_unit dut (.*);

  always #4 clk = ~clk;

  logic [39:0] request_q[$];
  word_t       flag_words_q[$];
  bit          base_prime[BaseLimit];
  int          mismatches = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_rx = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_cnt = 0;

  function automatic void sieve_range(logic [19:0] lo, logic [19:0] hi);
    bit seg[SegSize];
    int unsigned len, p, j, nw;
    word_t wd;
    if (hi < lo || hi - lo + 1 > SegSize) begin
      wd = '{64'd0, 4'd0, 1'b1, 1'b1};
      flag_words_q.insert(flag_words_q.size(), wd);
      return;
    end
    len = hi - lo + 1;
    for (int k = 0; k < len; k++) seg[k] = (lo + k) >= 2;
    for (p = 2; p < BaseLimit && p * p <= hi; p++) begin
      if (!base_prime[p]) continue;
      j = ((lo + p - 1) / p) * p;
      if (j < p * p) j = p * p;
      for (; j <= hi; j += p) seg[j - lo] = 1'b0;
    end
    nw = (len + 63) / 64;
    for (int w = 0; w < nw; w++) begin
      wd.flags = '0;
      for (int k = 0; k < 64; k++)
        if (w * 64 + k < len && seg[w * 64 + k]) wd.flags[k] = 1'b1;
      wd.widx = w[3:0];
      wd.last = (w + 1 == nw);
      wd.err = 1'b0;
      flag_words_q.insert(flag_words_q.size(), wd);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
    end else begin
      if (s_axis_tvalid) sieve_range(s_axis_tdata[19:0], s_axis_tdata[39:20]);
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        s_axis_tdata <= request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 8);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    word_t wd;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (flag_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", m_axis_tdata);
        end else begin
          wd = flag_words_q.pop_front();
          if (m_axis_tdata[63:0] !== wd.flags || m_axis_tdata[67:64] !== wd.widx ||
              m_axis_tuser !== wd.err || m_axis_tlast !== wd.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp flags %h idx %0d err %b last %b, %s %h idx %0d err %b last %b",
                       wd.flags, wd.widx, wd.err, wd.last, "got", m_axis_tdata[63:0],
                       m_axis_tdata[67:64], m_axis_tuser, m_axis_tlast);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_rx) begin
        hold_cnt <= 30000;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) rx_gap <= $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 8000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_range(int unsigned lo, int unsigned hi);
    request_q.insert(request_q.size(), {hi[19:0], lo[19:0]});
  endtask

  initial begin
    int unsigned lo, len;
    for (int i = 0; i < BaseLimit; i++) base_prime[i] = i >= 2;
    for (int i = 2; i * i < BaseLimit; i++)
      if (base_prime[i])
        for (int j = i * i; j < BaseLimit; j += i) base_prime[j] = 1'b0;

    add_range(0, 0);
    add_range(0, 1);
    add_range(0, 63);
    add_range(0, 1023);
    add_range(1, 64);
    add_range(2, 2);
    add_range(100, 99);
    add_range(1048575, 0);
    add_range(0, 1024);
    add_range(1047552, 1048575);
    add_range(1048575, 1048575);
    add_range(1048000, 1048100);
    add_range(961, 1100);
    add_range(524287, 525310);
    add_range(699050, 699050);
    add_range(349525, 350000);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // long receiver stall while the sender keeps offering
    add_range(500, 700);
    add_range(3, 5);
    add_range(7, 200);
    wait (request_q.size() == 0);
    @(posedge clk);
    hold_rx <= 1'b1;
    @(posedge clk);
    hold_rx <= 1'b0;

    for (int n = 0; n < 100; n++) begin
      case ($urandom_range(0, 9))
        0: begin lo = $urandom(); lo = lo[19:0]; len = $urandom_range(0, 1048575); end
        1: begin lo = $urandom_range(0, 1048575); len = 0; end
        2: begin lo = $urandom_range(0, 1048575); len = $urandom_range(1025, 5000); end
        3: begin lo = $urandom_range(0, 64); len = $urandom_range(1, 1024); end
        default: begin lo = $urandom_range(0, 1048575); len = $urandom_range(1, 1024); end
      endcase
      if (len == 0) add_range(lo, $urandom_range(0, lo == 0 ? 0 : lo - 1));
      else add_range(lo, (lo + len - 1) & 20'hFFFFF);
      if (n == 80) begin
        wait (request_q.size() == 0);
        no_idle = 1'b1;
      end
    end
    wait (request_q.size() == 0 && !s_axis_tvalid && flag_words_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && flag_words_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
